### rtl/core/chaotic_map_bit_generator_macros.svh
// ----------------------------------------------------------------------------
// Chaotic map bit generator assertion macros
// Shared property forms for the concurrent checks of the generator.
// ----------------------------------------------------------------------------
`ifndef CHAOTIC_MAP_BIT_GENERATOR_MACROS_SVH
`define CHAOTIC_MAP_BIT_GENERATOR_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define CMBG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define CMBG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/cmbg_pkg.sv
// ----------------------------------------------------------------------------
// Chaotic map bit generator package
// Control structs and register indexes shared by the generator modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cmbg_pkg;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam int SKIP_W     = 8;
  localparam int FRAC_W     = 5;

  localparam logic [CFG_IDX_W-1:0] REG_SKIP_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAC_BITS  = 1'd1;

  localparam logic [SKIP_W-1:0] SKIP_COUNT_RST = 8'd3;
  localparam logic [FRAC_W-1:0] FRAC_BITS_RST  = 5'd28;

  // Commands to the map datapath.
  typedef struct packed {
    logic load_half;
    logic iterate;
  } map_ctrl_t;

  // Commands to the extractor.
  typedef struct packed {
    logic clear;
    logic step;
    logic raw_bit;
  } ext_ctrl_t;

endpackage

### rtl/core/cmbg_map_unit.sv
// ----------------------------------------------------------------------------
// Chaotic map iteration unit
// Holds the map state and applies one map iteration per enabled cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cmbg_map_unit
  import cmbg_pkg::*;
#(
  parameter int STATE_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [FRAC_W-1:0] frac_bits,
  input  map_ctrl_t         ctrl,
  output logic              sign_bit
);

  // One half in the reset format, independent of the configuration register.
  localparam logic [STATE_WIDTH:0]   UNIT_RST = (STATE_WIDTH+1)'(1) << FRAC_BITS_RST;
  localparam logic [STATE_WIDTH-1:0] HALF_RST = UNIT_RST[STATE_WIDTH:1];

  logic [STATE_WIDTH-1:0] map_state_r;
  logic [STATE_WIDTH-1:0] map_state_nxt;
  logic [STATE_WIDTH:0]   unit_pos;
  logic [STATE_WIDTH-1:0] one_val;
  logic [STATE_WIDTH-1:0] half_val;
  logic [STATE_WIDTH-1:0] x_sh;
  logic [STATE_WIDTH-1:0] nx_base;

  // Bits at or above the state width drop out of the shift and read as zero.
  assign unit_pos = (STATE_WIDTH+1)'(1) << frac_bits;
  assign one_val  = unit_pos[STATE_WIDTH-1:0];
  assign half_val = unit_pos[STATE_WIDTH:1];

  assign x_sh    = STATE_WIDTH'($signed(map_state_r) >>> 3);
  assign nx_base = (map_state_r << 1) - x_sh;

  always_comb begin
    map_state_nxt = map_state_r;
    if (ctrl.load_half) begin
      map_state_nxt = half_val;
    end else if (ctrl.iterate) begin
      if (map_state_r[STATE_WIDTH-1]) begin
        map_state_nxt = nx_base + one_val;
      end else begin
        map_state_nxt = nx_base - one_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_state_r <= HALF_RST;
    end else begin
      map_state_r <= map_state_nxt;
    end
  end

  assign sign_bit = map_state_r[STATE_WIDTH-1];

endmodule

### rtl/core/cmbg_extractor.sv
// ----------------------------------------------------------------------------
// Von Neumann extractor and byte packer
// Pairs raw bits, keeps unequal pairs and packs kept bits MSB first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cmbg_extractor
  import cmbg_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  ext_ctrl_t  ctrl,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_rand_byte
);

  logic       pair_first_r,   pair_first_nxt;
  logic       pair_holds_r,   pair_holds_nxt;
  logic [7:0] byte_accum_r,   byte_accum_nxt;
  logic [2:0] kept_count_r,   kept_count_nxt;
  logic       out_valid_r,    out_valid_nxt;
  logic [7:0] out_byte_r,     out_byte_nxt;
  logic [7:0] byte_with_bit;

  always_comb begin
    byte_with_bit = byte_accum_r;
    byte_with_bit[3'd7 - kept_count_r] = pair_first_r;
  end

  always_comb begin
    pair_first_nxt = pair_first_r;
    pair_holds_nxt = pair_holds_r;
    byte_accum_nxt = byte_accum_r;
    kept_count_nxt = kept_count_r;
    out_byte_nxt   = out_byte_r;
    out_valid_nxt  = out_valid_r && !out_ready;

    if (ctrl.clear) begin
      pair_first_nxt = 1'b0;
      pair_holds_nxt = 1'b0;
      byte_accum_nxt = 8'd0;
      kept_count_nxt = 3'd0;
    end else if (ctrl.step) begin
      if (!pair_holds_r) begin
        pair_first_nxt = ctrl.raw_bit;
        pair_holds_nxt = 1'b1;
      end else begin
        pair_holds_nxt = 1'b0;
        if (pair_first_r != ctrl.raw_bit) begin
          if (kept_count_r == 3'd7) begin
            out_byte_nxt   = byte_with_bit;
            out_valid_nxt  = 1'b1;
            byte_accum_nxt = 8'd0;
            kept_count_nxt = 3'd0;
          end else begin
            byte_accum_nxt = byte_with_bit;
            kept_count_nxt = kept_count_r + 3'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_first_r <= 1'b0;
      pair_holds_r <= 1'b0;
      byte_accum_r <= 8'd0;
      kept_count_r <= 3'd0;
      out_valid_r  <= 1'b0;
    end else begin
      pair_first_r <= pair_first_nxt;
      pair_holds_r <= pair_holds_nxt;
      byte_accum_r <= byte_accum_nxt;
      kept_count_r <= kept_count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_rand_byte = out_byte_r;

endmodule

### rtl/core/chaotic_map_bit_generator.sv
// ----------------------------------------------------------------------------
// Chaotic map bit generator
// Debiased random bytes from a fixed-point chaotic map and a Von Neumann
// extractor.
// ----------------------------------------------------------------------------
// Each request on the input channel is one tick of the generator: it is
// accepted (and the map reloaded with one half when restart is set), then it
// runs skip_count silent map iterations and one sampled iteration, all on a
// single map iteration datapath that performs one iteration per cycle except
// while the sampled iteration is stalled. The input is not ready while a
// request is in progress.
// A completed byte is held in an output register until taken; a following
// request may be accepted and run meanwhile, and it waits in its sampled
// iteration for as long as the previous byte is still held. Configuration
// writes are expected while the generator is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "chaotic_map_bit_generator_macros.svh"

module chaotic_map_bit_generator
  import cmbg_pkg::*;
#(
  parameter int STATE_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration write port.
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // Request channel.
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_restart,
  // Result channel.
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_rand_byte
);

  // Sequencer states, one-hot.
  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_RUN    = 3'b010,
    ST_SAMPLE = 3'b100
  } seq_state_t;

  seq_state_t        state_r,      state_nxt;
  logic [SKIP_W-1:0] iter_cnt_r,   iter_cnt_nxt;
  logic [SKIP_W-1:0] skip_count_r, skip_count_nxt;
  logic [FRAC_W-1:0] frac_bits_r,  frac_bits_nxt;

  map_ctrl_t map_ctrl;
  ext_ctrl_t ext_ctrl;
  logic      sign_bit;
  logic      accept;
  logic      sample_go;

  // Configuration registers.
  always_comb begin
    skip_count_nxt = skip_count_r;
    frac_bits_nxt  = frac_bits_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_SKIP_COUNT: skip_count_nxt = cfg_wdata;
        REG_FRAC_BITS:  frac_bits_nxt  = cfg_wdata[FRAC_W-1:0];
        default: begin
          skip_count_nxt = skip_count_r;
        end
      endcase
    end
  end

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // The sampled iteration may complete a byte, so it only proceeds when the
  // output register is free or being emptied in this cycle.
  assign sample_go = (state_r == ST_SAMPLE) && (!out_valid || out_ready);

  // Sequencer: counts the silent iterations, then runs the sampled one.
  always_comb begin
    state_nxt    = state_r;
    iter_cnt_nxt = iter_cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          iter_cnt_nxt = skip_count_r;
          state_nxt    = (skip_count_r == '0) ? ST_SAMPLE : ST_RUN;
        end
      end
      ST_RUN: begin
        iter_cnt_nxt = iter_cnt_r - SKIP_W'(1);
        if (iter_cnt_r == SKIP_W'(1)) begin
          state_nxt = ST_SAMPLE;
        end
      end
      ST_SAMPLE: begin
        if (sample_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // The raw bit is the sign of the state before the sampled iteration.
  always_comb begin
    map_ctrl.load_half = accept && in_restart;
    map_ctrl.iterate   = (state_r == ST_RUN) || sample_go;
    ext_ctrl.clear     = accept && in_restart;
    ext_ctrl.step      = sample_go;
    ext_ctrl.raw_bit   = sign_bit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      iter_cnt_r   <= '0;
      skip_count_r <= SKIP_COUNT_RST;
      frac_bits_r  <= FRAC_BITS_RST;
    end else begin
      state_r      <= state_nxt;
      iter_cnt_r   <= iter_cnt_nxt;
      skip_count_r <= skip_count_nxt;
      frac_bits_r  <= frac_bits_nxt;
    end
  end

  cmbg_map_unit #(
    .STATE_WIDTH (STATE_WIDTH)
  ) u_map_unit (
    .clk       (clk),
    .rst_n     (rst_n),
    .frac_bits (frac_bits_r),
    .ctrl      (map_ctrl),
    .sign_bit  (sign_bit)
  );

  cmbg_extractor u_extractor (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl          (ext_ctrl),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_rand_byte (out_rand_byte)
  );

  // A byte only appears straight after a sampled iteration went ahead.
  `CMBG_ASSERT_NOW(a_byte_after_sample, $rose(out_valid),
    $past(sample_go), "result appeared without a sampled iteration")

  // An accepted request keeps the input closed in the next cycle.
  `CMBG_ASSERT_NEXT(a_busy_after_accept, accept, !in_ready,
    "input ready again straight after a request was accepted")

  // A held byte must not be overwritten by a stalled sampled iteration.
  `CMBG_ASSERT_NEXT(a_sample_stall,
    (state_r == ST_SAMPLE) && out_valid && !out_ready,
    (state_r == ST_SAMPLE) && out_valid && $stable(out_rand_byte),
    "sampled iteration ran while the output byte was still held")

endmodule

### tb/tb_chaotic_map_bit_generator.sv
// ----------------------------------------------------------------------------
// Chaotic map bit generator testbench
// Drives ticks into the generator through the request channel and checks every
// random byte it returns against a cycle-free model of the map, the Von Neumann
// extractor and the byte packer, across several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_chaotic_map_bit_generator;
  import cmbg_pkg::*;

  localparam int STATE_W     = 32;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int ITEM_TARGET = 1250;

  // --------------------------------------------------------------------------
  // Scoreboard. It carries its own copy of the generator state and registers.
  // Every accepted request advances that copy by one tick, and any byte the
  // tick completes is queued until the generator hands one back.
  // --------------------------------------------------------------------------
  class rand_byte_scoreboard;
    logic [7:0]         skip;
    logic [4:0]         frac;
    logic [STATE_W-1:0] map_state;
    bit                 pair_first;
    bit                 pair_full;
    logic [7:0]         byte_acc;
    int                 kept;
    logic [7:0]         expected_bytes[$];
    int                 failures;

    function new();
      skip       = SKIP_COUNT_RST;
      frac       = FRAC_BITS_RST;
      failures   = 0;
      clear_tick_state();
    endfunction

    // A single bit of the fixed-point format; positions past the top of the
    // state fall away and give zero.
    function logic [STATE_W-1:0] fixed_bit(int pos);
      if (pos >= STATE_W) return '0;
      return {{(STATE_W-1){1'b0}}, 1'b1} << pos;
    endfunction

    // One half in the current format. With no fraction bits it has no bit.
    function logic [STATE_W-1:0] half_value();
      if (frac == 0) return '0;
      return fixed_bit(int'(frac) - 1);
    endfunction

    function void clear_tick_state();
      map_state  = half_value();
      pair_first = 1'b0;
      pair_full  = 1'b0;
      byte_acc   = '0;
      kept       = 0;
    endfunction

    // x = 2x - (x >>> 3) + 1 when negative, - 1 otherwise, modulo 2^STATE_W.
    function void map_iterate();
      logic [STATE_W-1:0] shifted;
      logic [STATE_W-1:0] one_val;
      shifted = $signed(map_state) >>> 3;
      one_val = fixed_bit(int'(frac));
      if (map_state[STATE_W-1]) begin
        map_state = (map_state << 1) - shifted + one_val;
      end else begin
        map_state = (map_state << 1) - shifted - one_val;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_SKIP_COUNT) begin
        skip = data[SKIP_W-1:0];
      end else if (idx == REG_FRAC_BITS) begin
        frac = data[FRAC_W-1:0];
      end
    endfunction

    // Advances the model by one tick for an accepted request.
    function void note_request(bit restart);
      bit raw;
      if (restart) clear_tick_state();
      for (int i = 0; i < int'(skip); i++) map_iterate();
      raw = map_state[STATE_W-1];
      map_iterate();
      if (!pair_full) begin
        pair_first = raw;
        pair_full  = 1'b1;
        return;
      end
      pair_full = 1'b0;
      if (pair_first == raw) return;
      if (pair_first) byte_acc[7-kept] = 1'b1;
      kept++;
      if (kept == 8) begin
        expected_bytes.push_back(byte_acc);
        byte_acc = '0;
        kept     = 0;
      end
    endfunction

    function void check_byte(logic [7:0] actual);
      logic [7:0] exp_byte;
      if (expected_bytes.size() == 0) begin
        $display("%0t: rand_byte expected none, actual %02h", $time, actual);
        failures++;
        return;
      end
      exp_byte = expected_bytes.pop_front();
      if (actual !== exp_byte) begin
        $display("%0t: rand_byte expected %02h, actual %02h", $time, exp_byte, actual);
        failures++;
      end
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block under test and its stimulus signals.
  // --------------------------------------------------------------------------
  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_restart;
  logic                  out_valid;
  logic                  out_ready;
  logic [7:0]            out_rand_byte;

  rand_byte_scoreboard sb;
  int                  send_idle_pct;
  int                  recv_idle_pct;
  int                  cycle_count;
  int                  items_sent;

  chaotic_map_bit_generator #(
    .STATE_WIDTH(STATE_W)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_restart   (in_restart),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_rand_byte(out_rand_byte)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Safety net: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Receiver. A byte is taken at an edge where valid and ready were both high
  // just before it; ready for the next cycle is then rolled against the
  // current stall rate, so stalls land on every phase of a tick.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      sb.check_byte(out_rand_byte);
    end
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // --------------------------------------------------------------------------
  // Driving tasks. Each is entered just after a rising edge and returns just
  // after one, so the next assignment always lands in a fresh time step.
  // --------------------------------------------------------------------------

  // Offers one request, with random idle cycles in front of it, and notes it
  // in the scoreboard on the edge at which it is taken. When no idle cycle is
  // drawn, valid simply stays high into the next request.
  task automatic send_request(input bit restart);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_request(restart);
    items_sent++;
  endtask

  // Holds the sender off until every expected byte has come back. It always
  // waits for a clock edge first, so valid is never lowered and raised in one step.
  task automatic drain_bytes();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Registers may only change while the generator is idle. Once the last byte
  // is back, a tick that yielded nothing may still be iterating, so the writes
  // wait long enough for that tick to finish first.
  task automatic apply_settings(input logic [7:0] skip, input logic [4:0] frac);
    drain_bytes();
    repeat (int'(sb.skip) + 10) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SKIP_COUNT;
    cfg_wdata <= skip;
    @(posedge clk);
    sb.write_reg(REG_SKIP_COUNT, skip);
    cfg_index <= REG_FRAC_BITS;
    cfg_wdata <= {3'b000, frac};
    @(posedge clk);
    sb.write_reg(REG_FRAC_BITS, {3'b000, frac});
    cfg_we    <= 1'b0;
  endtask

  // A short directed run: bit i of the pattern is the restart flag of item i.
  task automatic directed_run(input logic [7:0] pattern, input int count);
    for (int i = 0; i < count; i++) send_request(pattern[i]);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    logic [7:0] skip_sel;
    logic [4:0] frac_sel;
    int         phase_len;
    sb            = new();
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    in_valid      = 1'b0;
    in_restart    = 1'b0;
    out_ready     = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    cycle_count   = 0;
    items_sent    = 0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. The reset settings come first, with a restart in the
    // middle of the run. Then zero fraction bits with a request before any
    // restart, so the state keeps its old scaling while the constant one
    // changes at once; the top of the skip range with the constant one on
    // the sign bit; one fraction bit; and zero skip with a wide fraction.
    directed_run(8'b0000_0100, 5);
    apply_settings(8'd0, 5'd0);
    directed_run(8'b0000_0010, 4);
    apply_settings(8'd255, 5'd31);
    directed_run(8'b0000_0010, 3);
    apply_settings(8'd1, 5'd1);
    directed_run(8'b0000_0001, 4);
    apply_settings(8'd0, 5'd30);
    directed_run(8'b0000_0100, 4);

    // Random part. Restarts are rare, since each one throws away the byte in
    // progress and a byte takes some thirty ticks to fill. Most phases use a
    // short skip and a fraction width in the useful range; now and then a
    // phase takes any width, and a few short phases run with a long skip.
    items_sent = 0;
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 7) == 0) begin
        skip_sel  = 8'($urandom_range(200, 255));
        phase_len = 8;
      end else begin
        skip_sel  = 8'($urandom_range(0, 6));
        phase_len = $urandom_range(60, 140);
      end
      if ($urandom_range(0, 4) == 0) begin
        frac_sel = 5'($urandom_range(0, 31));
      end else begin
        frac_sel = 5'($urandom_range(20, 30));
      end
      apply_settings(skip_sel, frac_sel);
      for (int i = 0; i < phase_len && items_sent < ITEM_TARGET; i++) begin
        // Idle profile by progress: slow receiver first, then slow sender,
        // then both running flat out.
        if (items_sent < ITEM_TARGET / 3) begin
          send_idle_pct = 19;
          recv_idle_pct = 48;
        end else if (items_sent < 2 * ITEM_TARGET / 3) begin
          send_idle_pct = 48;
          recv_idle_pct = 19;
        end else begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        // Occasionally hold the sender until the generator has handed back
        // everything it owes.
        if ($urandom_range(0, 199) == 0) drain_bytes();
        send_request($urandom_range(0, 249) == 0);
      end
    end

    // Wind-down: wait for the outstanding bytes, then long enough for any tick
    // still iterating to show a stray byte.
    drain_bytes();
    repeat (int'(sb.skip) + 20) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
